[hdl/line_edit_buffer_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef LINE_EDIT_BUFFER_UNIT_MACROS_SVH
`define LINE_EDIT_BUFFER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LEB_ASSERT_IMP(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define LEB_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);
`endif

[hdl/leb_pkg.sv]
// Package with types and constants of the line edit buffer.
`timescale 1ns / 1ps
package leb_pkg;
  localparam logic [0:0] REG_PROMPT     = 1'b0;
  localparam logic [0:0] REG_COPY_LIMIT = 1'b1;

  localparam logic [2:0] ACT_CHAR  = 3'd0;
  localparam logic [2:0] ACT_LEFT  = 3'd1;
  localparam logic [2:0] ACT_RIGHT = 3'd2;
  localparam logic [2:0] ACT_HOME  = 3'd3;
  localparam logic [2:0] ACT_END   = 3'd4;
  localparam logic [2:0] ACT_DEL   = 3'd5;

  localparam logic [7:0] KEY_LINE_START = 8'd1;
  localparam logic [7:0] KEY_EOF   = 8'd4;
  localparam logic [7:0] KEY_END   = 8'd5;
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_ENTER = 8'd10;
  localparam logic [7:0] KEY_KILLE = 8'd11;
  localparam logic [7:0] KEY_CLEAR = 8'd12;
  localparam logic [7:0] KEY_KILLS = 8'd21;
  localparam logic [7:0] KEY_KILLW = 8'd23;
  localparam logic [7:0] KEY_SPACE = 8'd32;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_EOF    = 2'd3;

  localparam logic [2:0] RD_NONE  = 3'd0;
  localparam logic [2:0] RD_MOVE  = 3'd1;
  localparam logic [2:0] RD_ERASE = 3'd2;
  localparam logic [2:0] RD_LINE  = 3'd3;
  localparam logic [2:0] RD_CLEAR = 3'd4;

  // Codes above the visible redraw values mark work still pending inside the block.
  localparam logic [2:0] PEND_EOF    = 3'd5;
  localparam logic [2:0] PEND_SEND   = 3'd6;
  localparam logic [2:0] PEND_INSERT = 3'd7;

  // Operation applied along the selected span of the row of cells.
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_LEFT,
    SH_RIGHT
  } shift_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN_SP,
    ST_SCAN_WD,
    ST_SEND,
    ST_REPORT
  } state_t;
endpackage

[hdl/leb_cell.sv]
// One byte cell of the line store: holds, loads or takes a neighbor's byte.
`timescale 1ns / 1ps
module leb_cell (
  input  logic              clk,
  input  leb_pkg::shift_op_t op,
  input  logic              sel,
  input  logic              load,
  input  logic [7:0]        load_byte,
  input  logic [7:0]        from_left,
  input  logic [7:0]        from_right,
  output logic [7:0]        data
);
  import leb_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_byte;
    end else if (sel) begin
      case (op)
        SH_LEFT:  data <= from_right;
        SH_RIGHT: data <= from_left;
        default:  data <= data;
      endcase
    end
  end
endmodule

[hdl/line_edit_buffer_unit.sv]
// Line edit buffer: key events edit a row of byte cells; Enter streams out the line.
// Edits shift the span one position per shift step; kill word first scans back over
// spaces, then the word. Enter sends from cell zero, shifting the row after each byte;
// a stalled result holds it. The next item waits until the last result is registered.
// Reset (rst, synchronous) clears state, length, cursor, out_valid and prompt length,
// and sets the copy limit to 64; the store is not cleared.
`timescale 1ns / 1ps
module line_edit_buffer_unit #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] key_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] line_byte,
  output logic [5:0] cursor,
  output logic [5:0] length,
  output logic [8:0] column,
  output logic [2:0] redraw,
  output logic       last
);
  import leb_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int LW = $clog2(LINE_CAPACITY + 1);

  logic [7:0]    prompt_length;
  logic [6:0]    copy_limit;
  logic [LW-1:0] text_length, text_length_next;
  logic [LW-1:0] cursor_position, cursor_position_next;
  state_t        state, state_next;

  // Shift bookkeeping: span [lo, hi) moves, cnt steps remaining.
  logic [LW-1:0] lo, lo_next, hi, hi_next, cnt, cnt_next;
  logic [LW-1:0] pos, pos_next;
  logic [LW-1:0] send_n, send_n_next;
  logic [2:0]    pend_redraw, pend_redraw_next;
  shift_op_t     op, op_next;
  logic [7:0]    ins_byte, ins_byte_next;

  logic [7:0] cells [LINE_CAPACITY];
  logic       load;
  logic [AW-1:0] load_idx;
  logic [7:0] load_byte;
  logic [7:0] head_byte;

  // Output register.
  logic       o_valid, o_valid_next;
  logic [1:0] o_kind, o_kind_next;
  logic [7:0] o_byte, o_byte_next;
  logic [2:0] o_redraw, o_redraw_next;
  logic       o_last, o_last_next;
  logic [LW-1:0] o_cur, o_cur_next, o_len, o_len_next;

  logic       can_emit;
  logic [6:0] cut;
  logic [7:0] scan_byte;

  assign can_emit = !o_valid || !out_stall;
  assign cut = (copy_limit == 7'd0) ? 7'd0 : copy_limit - 7'd1;
  assign head_byte = cells[0];

  genvar g;
  generate
    for (g = 0; g < LINE_CAPACITY; g++) begin : g_cell
      logic sel;
      logic [7:0] fl, fr;
      assign sel = (LW'(g) >= lo) && (LW'(g) < hi);
      if (g == 0) begin : g_l
        assign fl = cells[0];
      end else begin : g_lm
        assign fl = cells[g-1];
      end
      if (g == LINE_CAPACITY - 1) begin : g_r
        assign fr = cells[g];
      end else begin : g_rm
        assign fr = cells[g+1];
      end
      leb_cell u_cell (
        .clk(clk), .op(op), .sel(sel && (state == ST_SHIFT)),
        .load(load && (load_idx == AW'(g))), .load_byte(load_byte),
        .from_left(fl), .from_right(fr), .data(cells[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      prompt_length <= 8'd0;
      copy_limit    <= 7'd64;
    end else if (cfg_write) begin
      if (cfg_index == REG_PROMPT) prompt_length <= cfg_data;
      else copy_limit <= cfg_data[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      text_length <= '0;
      cursor_position <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      text_length <= text_length_next;
      cursor_position <= cursor_position_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next; hi <= hi_next; cnt <= cnt_next; pos <= pos_next;
    send_n <= send_n_next; pend_redraw <= pend_redraw_next; op <= op_next;
    ins_byte <= ins_byte_next;
    o_kind <= o_kind_next; o_byte <= o_byte_next; o_redraw <= o_redraw_next;
    o_last <= o_last_next; o_cur <= o_cur_next; o_len <= o_len_next;
    // The word scan reads the byte just left of the next scan position.
    scan_byte <= cells[AW'(pos_next - LW'(1))];
  end

  always_comb begin
    state_next = state;
    text_length_next = text_length;
    cursor_position_next = cursor_position;
    lo_next = lo; hi_next = hi; cnt_next = cnt; pos_next = pos;
    send_n_next = send_n; pend_redraw_next = pend_redraw; op_next = op;
    ins_byte_next = ins_byte;
    o_valid_next = o_valid && out_stall;
    o_kind_next = o_kind; o_byte_next = o_byte; o_redraw_next = o_redraw;
    o_last_next = o_last; o_cur_next = o_cur; o_len_next = o_len;
    load = 1'b0; load_idx = '0; load_byte = key_byte;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_REPORT;
          pend_redraw_next = RD_NONE;
          case (action)
            ACT_LEFT: if (cursor_position != '0) begin
              cursor_position_next = cursor_position - LW'(1);
              pend_redraw_next = RD_MOVE;
            end
            ACT_RIGHT: if (cursor_position < text_length) begin
              cursor_position_next = cursor_position + LW'(1);
              pend_redraw_next = RD_MOVE;
            end
            ACT_HOME: begin
              cursor_position_next = '0; pend_redraw_next = RD_MOVE;
            end
            ACT_END: begin
              cursor_position_next = text_length; pend_redraw_next = RD_MOVE;
            end
            ACT_DEL: if (cursor_position < text_length) begin
              // Close the gap: bytes above the cursor move down by one.
              lo_next = cursor_position; hi_next = text_length - LW'(1);
              cnt_next = LW'(1); op_next = SH_LEFT;
              text_length_next = text_length - LW'(1);
              pend_redraw_next = RD_LINE; state_next = ST_SHIFT;
            end
            ACT_CHAR: begin
              case (key_byte)
                KEY_ENTER: begin
                  send_n_next = (int'(text_length) > int'(cut)) ? LW'(cut) : text_length;
                  text_length_next = '0; cursor_position_next = '0;
                  state_next = ST_SEND;
                end
                KEY_EOF: if (text_length == '0) begin
                  state_next = ST_SEND; send_n_next = '0;
                  pend_redraw_next = PEND_EOF;
                end
                KEY_LINE_START: begin
                  cursor_position_next = '0; pend_redraw_next = RD_MOVE;
                end
                KEY_END: begin
                  cursor_position_next = text_length; pend_redraw_next = RD_MOVE;
                end
                KEY_KILLE: begin
                  text_length_next = cursor_position; pend_redraw_next = RD_ERASE;
                end
                KEY_CLEAR: pend_redraw_next = RD_CLEAR;
                KEY_KILLS: if (cursor_position != '0) begin
                  lo_next = '0; hi_next = text_length - LW'(1);
                  cnt_next = cursor_position; op_next = SH_LEFT;
                  text_length_next = text_length - cursor_position;
                  cursor_position_next = '0;
                  pend_redraw_next = RD_LINE; state_next = ST_SHIFT;
                end
                KEY_KILLW: if (cursor_position != '0) begin
                  pos_next = cursor_position; state_next = ST_SCAN_SP;
                end
                KEY_BS: if (cursor_position != '0) begin
                  lo_next = cursor_position - LW'(1); hi_next = text_length - LW'(1);
                  cnt_next = LW'(1); op_next = SH_LEFT;
                  text_length_next = text_length - LW'(1);
                  cursor_position_next = cursor_position - LW'(1);
                  pend_redraw_next = RD_LINE; state_next = ST_SHIFT;
                end
                default: begin
                  if (key_byte >= KEY_SPACE && !key_byte[7]
                      && (text_length + LW'(1) < LW'(LINE_CAPACITY))) begin
                    // Open a gap with one right shift and load the byte at the same edge.
                    lo_next = cursor_position + LW'(1); hi_next = text_length + LW'(1);
                    cnt_next = LW'(1); op_next = SH_RIGHT;
                    pos_next = cursor_position;
                    ins_byte_next = key_byte;
                    text_length_next = text_length + LW'(1);
                    cursor_position_next = cursor_position + LW'(1);
                    pend_redraw_next = PEND_INSERT;
                    state_next = ST_SHIFT;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_SP: begin
        if (pos != '0 && scan_byte == KEY_SPACE) pos_next = pos - LW'(1);
        else state_next = ST_SCAN_WD;
      end
      ST_SCAN_WD: begin
        if (pos != '0 && scan_byte != KEY_SPACE) pos_next = pos - LW'(1);
        else begin
          lo_next = pos; hi_next = text_length - LW'(1);
          cnt_next = cursor_position - pos; op_next = SH_LEFT;
          text_length_next = text_length - (cursor_position - pos);
          cursor_position_next = pos;
          pend_redraw_next = RD_LINE;
          state_next = (cursor_position == pos) ? ST_REPORT : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cnt_next = cnt - LW'(1);
        if (cnt == LW'(1)) begin
          state_next = ST_REPORT;
          if (pend_redraw == PEND_INSERT) begin
            // The cell at the old cursor sits below the moving span.
            load = 1'b1; load_idx = AW'(pos); load_byte = ins_byte;
            pend_redraw_next = RD_LINE;
          end
        end
      end
      ST_SEND: begin
        if (can_emit) begin
          o_valid_next = 1'b1; o_cur_next = '0; o_len_next = '0;
          o_redraw_next = RD_NONE; o_byte_next = 8'd0;
          if (pend_redraw == PEND_EOF) begin
            o_kind_next = KIND_EOF; o_last_next = 1'b1; o_cur_next = cursor_position;
            state_next = ST_IDLE;
          end else if (send_n == '0) begin
            o_kind_next = KIND_EMPTY; o_last_next = 1'b1; state_next = ST_IDLE;
          end else begin
            o_kind_next = KIND_BYTE; o_byte_next = head_byte;
            o_last_next = (send_n == LW'(1));
            send_n_next = send_n - LW'(1);
            // Shift the row down so the next byte reaches cell zero.
            lo_next = '0; hi_next = LW'(LINE_CAPACITY - 1); cnt_next = LW'(1);
            op_next = SH_LEFT;
            state_next = (send_n == LW'(1)) ? ST_IDLE : ST_SHIFT;
            pend_redraw_next = PEND_SEND;
          end
        end
      end
      ST_REPORT: begin
        if (pend_redraw == PEND_SEND) begin
          state_next = ST_SEND;
        end else if (can_emit) begin
          o_valid_next = 1'b1; o_kind_next = KIND_STATUS; o_byte_next = 8'd0;
          o_redraw_next = pend_redraw; o_last_next = 1'b1;
          o_cur_next = cursor_position; o_len_next = text_length;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // During a line send the shift step returns to sending.
    if (state == ST_SHIFT && pend_redraw == PEND_SEND) state_next = ST_SEND;
  end

  assign out_valid = o_valid;
  assign kind = o_kind;
  assign line_byte = o_byte;
  assign cursor = o_cur[5:0];
  assign length = o_len[5:0];
  assign column = 9'(prompt_length) + 9'(o_cur);
  assign redraw = o_redraw;
  assign last = o_last;
endmodule

[hdl/leb_checker.sv]
// Port-level checker for the line edit buffer, bound to the top level.
`timescale 1ns / 1ps
`include "line_edit_buffer_unit_macros.svh"
module leb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [5:0] cursor,
  input logic [5:0] length,
  input logic [2:0] redraw,
  input logic       last
);
  import leb_pkg::*;
  `LEB_ASSERT_IMP(a_cur_le_len, out_valid && kind == KIND_STATUS, cursor <= length, "cursor past length")
  `LEB_ASSERT_IMP(a_sub_zero, out_valid && kind != KIND_STATUS, redraw == RD_NONE, "redraw on submit")
  `LEB_ASSERT_IMP(a_status_last, out_valid && kind == KIND_STATUS, last, "status not last")
  `LEB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind), "result dropped")
  `LEB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid, "input item dropped")
endmodule

bind line_edit_buffer_unit leb_checker u_leb_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .cursor(cursor),
  .length(length), .redraw(redraw), .last(last)
);

[verif/line_edit_buffer_unit_tb.sv]
// Self-checking testbench for the line edit buffer: directed and random key events against a predictor.
`timescale 1ns / 1ps
module line_edit_buffer_unit_tb;
  import leb_pkg::*;

  localparam int CAP = 64;
  localparam int LIMIT_CYCLES = 900000;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] key_byte;
  } key_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] line_byte;
    logic [5:0] cursor;
    logic [5:0] length;
    logic [8:0] column;
    logic [2:0] redraw;
    logic       last;
  } edit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [7:0] key_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] line_byte;
  logic [5:0] cursor;
  logic [5:0] length;
  logic [8:0] column;
  logic [2:0] redraw;
  logic last;

  line_edit_buffer_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted editor state.
  logic [7:0] line_text [CAP];
  int unsigned text_len, cur_pos, prompt_cols, buf_size;

  key_item_t pending_keys[$];
  edit_result_t expected_results[$];
  int unsigned send_idle_pct, recv_stall_pct, hold_cycles;
  int unsigned cycle_count, errors;

  function automatic edit_result_t make_result(logic [1:0] k, logic [7:0] b,
                                               logic [2:0] rd, logic lst);
    edit_result_t r;
    r.kind = k;
    r.line_byte = b;
    r.cursor = cur_pos[5:0];
    r.length = text_len[5:0];
    r.column = 9'(prompt_cols + cur_pos);
    r.redraw = rd;
    r.last = lst;
    return r;
  endfunction

  task automatic cut_span(int unsigned from, int unsigned cnt);
    if (cnt == 0 || from + cnt > text_len) return;
    for (int unsigned i = from; i + cnt < text_len; i++) line_text[i] = line_text[i + cnt];
    text_len -= cnt;
  endtask

  task automatic predict_edit(key_item_t it);
    logic [2:0] rd;
    int unsigned n, p;
    logic [7:0] c;
    rd = RD_NONE;
    c = it.key_byte;
    case (it.action)
      ACT_LEFT: if (cur_pos > 0) begin cur_pos--; rd = RD_MOVE; end
      ACT_RIGHT: if (cur_pos < text_len) begin cur_pos++; rd = RD_MOVE; end
      ACT_HOME: begin cur_pos = 0; rd = RD_MOVE; end
      ACT_END: begin cur_pos = text_len; rd = RD_MOVE; end
      ACT_DEL: if (cur_pos < text_len) begin cut_span(cur_pos, 1); rd = RD_LINE; end
      ACT_CHAR: begin
        if (c == KEY_ENTER) begin
          n = (buf_size == 0) ? 0 : buf_size - 1;
          if (n > 63) n = 63;
          if (n > text_len) n = text_len;
          text_len = 0;
          cur_pos = 0;
          if (n == 0) expected_results.push_back(make_result(KIND_EMPTY, 8'd0, RD_NONE, 1'b1));
          for (int unsigned i = 0; i < n; i++)
            expected_results.push_back(make_result(KIND_BYTE, line_text[i], RD_NONE, i + 1 == n));
          return;
        end
        if (c == KEY_EOF) begin
          if (text_len == 0) begin
            expected_results.push_back(make_result(KIND_EOF, 8'd0, RD_NONE, 1'b1));
            return;
          end
        end else if (c == KEY_LINE_START) begin
          cur_pos = 0; rd = RD_MOVE;
        end else if (c == KEY_END) begin
          cur_pos = text_len; rd = RD_MOVE;
        end else if (c == KEY_KILLE) begin
          text_len = cur_pos; rd = RD_ERASE;
        end else if (c == KEY_KILLS) begin
          if (cur_pos > 0) begin cut_span(0, cur_pos); cur_pos = 0; rd = RD_LINE; end
        end else if (c == KEY_KILLW) begin
          if (cur_pos > 0) begin
            p = cur_pos;
            while (p > 0 && line_text[p - 1] == KEY_SPACE) p--;
            while (p > 0 && line_text[p - 1] != KEY_SPACE) p--;
            cut_span(p, cur_pos - p);
            cur_pos = p;
            rd = RD_LINE;
          end
        end else if (c == KEY_CLEAR) begin
          rd = RD_CLEAR;
        end else if (c == KEY_BS) begin
          if (cur_pos > 0) begin cut_span(cur_pos - 1, 1); cur_pos--; rd = RD_LINE; end
        end else if (c >= 32 && c < 128 && text_len + 1 < CAP) begin
          for (int unsigned i = text_len; i > cur_pos; i--) line_text[i] = line_text[i - 1];
          line_text[cur_pos] = c;
          cur_pos++;
          text_len++;
          rd = RD_LINE;
        end
      end
      default: ;
    endcase
    expected_results.push_back(make_result(KIND_STATUS, 8'd0, rd, 1'b1));
  endtask

  // Driver: offers the next queued item; the payload holds while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_edit({action, key_byte});
        void'(pending_keys.pop_front());
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        action <= pending_keys[0].action;
        key_byte <= pending_keys[0].key_byte;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    edit_result_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {kind, line_byte, cursor, length, column, redraw, last};
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
          end
          if (got.line_byte != want.line_byte) begin
            $error("line_byte: expected %0d, got %0d", want.line_byte, got.line_byte); errors++;
          end
          if (got.cursor != want.cursor) begin
            $error("cursor: expected %0d, got %0d", want.cursor, got.cursor); errors++;
          end
          if (got.length != want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length); errors++;
          end
          if (got.column != want.column) begin
            $error("column: expected %0d, got %0d", want.column, got.column); errors++;
          end
          if (got.redraw != want.redraw) begin
            $error("redraw: expected %0d, got %0d", want.redraw, got.redraw); errors++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); errors++;
          end
        end
      end
    end
  end

  // Receiver stall, with a long hold-off counted down here when requested.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("line_edit_buffer_unit_tb failed");
      $finish;
    end
  end

  task automatic queue_key(logic [2:0] act, logic [7:0] b);
    key_item_t it;
    it.action = act;
    it.key_byte = b;
    pending_keys.push_back(it);
  endtask

  task automatic drain;
    while (pending_keys.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // Non-final events may still be in flight after the last result.
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_PROMPT) prompt_cols = val;
    else buf_size = val[6:0];
  endtask

  task automatic queue_word;
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) queue_key(ACT_CHAR, 8'($urandom_range(33, 126)));
    if ($urandom_range(2) == 0) queue_key(ACT_CHAR, KEY_SPACE);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned r;
    logic [7:0] ctl [10];
    ctl = '{KEY_LINE_START, KEY_EOF, KEY_END, KEY_BS, KEY_ENTER, KEY_KILLE, KEY_CLEAR,
            KEY_KILLS, KEY_KILLW, 8'd0};
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 35) queue_key(ACT_CHAR, 8'($urandom_range(32, 126)));
      else if (r < 45) queue_word();
      else if (r < 65) queue_key(3'($urandom_range(1, 5)), 8'($urandom));
      else if (r < 85) queue_key(ACT_CHAR, ctl[$urandom_range(9)]);
      else if (r < 92) queue_key(ACT_CHAR, 8'($urandom));
      else if (r < 95) queue_key(3'($urandom_range(6, 7)), 8'($urandom));
      else queue_key(ACT_CHAR, KEY_ENTER);
    end
  endtask

  initial begin
    text_len = 0; cur_pos = 0; prompt_cols = 0; buf_size = 64;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    cycle_count = 0; errors = 0;
    for (int i = 0; i < CAP; i++) line_text[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-line cases, every action, controls, then a full line.
    queue_key(ACT_CHAR, KEY_EOF);
    queue_key(ACT_CHAR, KEY_ENTER);
    queue_key(ACT_LEFT, 8'hFF);
    queue_key(ACT_DEL, 8'h00);
    queue_key(ACT_CHAR, KEY_BS);
    queue_key(ACT_CHAR, 8'd65);
    queue_key(ACT_CHAR, KEY_SPACE);
    queue_key(ACT_CHAR, 8'd127);
    queue_key(ACT_CHAR, 8'd128);
    queue_key(ACT_CHAR, 8'd255);
    queue_key(ACT_CHAR, 8'd7);
    queue_key(3'd6, 8'd65);
    queue_key(3'd7, 8'd0);
    queue_key(ACT_HOME, 8'd0);
    queue_key(ACT_RIGHT, 8'd0);
    queue_key(ACT_END, 8'd0);
    queue_key(ACT_RIGHT, 8'd0);
    queue_key(ACT_CHAR, KEY_KILLW);
    queue_key(ACT_CHAR, KEY_EOF);
    queue_key(ACT_CHAR, KEY_LINE_START);
    queue_key(ACT_CHAR, KEY_END);
    queue_key(ACT_CHAR, KEY_CLEAR);
    queue_key(ACT_CHAR, KEY_KILLS);
    queue_key(ACT_CHAR, KEY_KILLE);
    queue_key(ACT_CHAR, KEY_ENTER);
    repeat (66) queue_key(ACT_CHAR, 8'($urandom_range(32, 126)));
    queue_key(ACT_CHAR, KEY_ENTER);
    drain();

    // Random phases with different register settings, input idling and receiver stalls.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_PROMPT, ph == 0 ? 8'd255 : 8'($urandom));
      write_reg(REG_COPY_LIMIT,
                ph == 0 ? 8'd1 : ph == 1 ? 8'd64 : ph == 2 ? 8'd0 : 8'($urandom_range(2, 127)));
      cfg_write <= 1'b0;
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 34) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 34) : 0;
      if (ph == 1) hold_cycles = 400;
      queue_random(25);
      queue_key(ACT_CHAR, KEY_ENTER);
      drain();
    end
    if (errors == 0) $display("line_edit_buffer_unit_tb passed");
    else $display("line_edit_buffer_unit_tb failed");
    $finish;
  end
endmodule
